[rtl/core/wfgd_pkg.sv]
// Package for the wait-for graph deadlock detector.
// Holds sizes, the op codes and the word and table-port types.
// No dependencies.
package wfgd_pkg;

    // Sizes; the index fields are 3 bits wide.
    localparam int THREAD_COUNT   = 8;
    localparam int RESOURCE_COUNT = 8;
    localparam int THREAD_W       = 3;
    localparam int RESOURCE_W     = 3;
    localparam int PATH_DEPTH     = THREAD_COUNT + 1;
    localparam int PATH_AW        = 4;

    // Table entry meaning none / free.
    localparam logic [3:0] NONE_VAL = 4'hF;

    typedef enum logic [1:0] {
        OP_SET_WAIT   = 2'd0,
        OP_SET_HOLDER = 2'd1,
        OP_DETECT     = 2'd2
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [THREAD_W-1:0]    thread_index;
        logic [RESOURCE_W-1:0]  resource_index;
        logic signed [3:0]      wait_resource;
        logic signed [3:0]      holder_thread;
    } t_in_word;

    typedef struct packed {
        logic                   found;
        logic [THREAD_W-1:0]    cycle_thread;
        logic [3:0]             position;
        logic [3:0]             cycle_length;
        logic [THREAD_W-1:0]    victim_thread;
        logic                   last;
    } t_out_word;

    // Table write request.
    typedef struct packed {
        logic                   wait_we;
        logic                   hold_we;
        logic [THREAD_W-1:0]    thread;
        logic [RESOURCE_W-1:0]  resource;
        logic [3:0]             wait_val;
        logic [3:0]             hold_val;
    } t_tbl_wr;

    // Table read addresses.
    typedef struct packed {
        logic [THREAD_W-1:0]    wait_addr;
        logic [RESOURCE_W-1:0]  hold_addr;
    } t_tbl_rd;

endpackage

[rtl/core/wait_for_graph_deadlock_detector.sv]
// Wait-for graph deadlock detector, top level.
// Table update words: written to the tables on accept; the input stays ready for the next word.
// Detect: each start thread is checked in turn and, if it waits, its chain of holders is
// followed until a holder repeats or a link ends; the repeat is then located and one word
// per cycle thread plus a closing word is sent, else one no-cycle word. Output stalls wait.
// One word at a time. Synchronous active-low reset; tables read as empty via valid bits.
module wait_for_graph_deadlock_detector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wfgd_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wfgd_pkg::t_out_word  o_out_word
);
    import wfgd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CHK_START,
        S_HOLD,
        S_WAIT,
        S_POS,
        S_EMIT_RD,
        S_EMIT,
        S_CLOSE,
        S_NONE
    } t_state;

    t_state                  r_state;
    logic [PATH_AW-1:0]      r_start;
    logic [PATH_AW-1:0]      r_len;
    logic [PATH_AW-1:0]      r_ptr;
    logic [3:0]              r_pos;
    logic [3:0]              r_clen;
    logic [THREAD_COUNT-1:0] r_on_path;
    logic [THREAD_W-1:0]     r_victim;
    logic [THREAD_W-1:0]     r_close;

    t_tbl_wr                 tbl_wr;
    t_tbl_rd                 tbl_rd;
    logic [3:0]              wait_data;
    logic [3:0]              hold_data;
    logic [THREAD_W-1:0]     hold_thr;
    logic                    path_we;
    logic [PATH_AW-1:0]      path_waddr;
    logic [THREAD_W-1:0]     path_wdata;
    logic [THREAD_W-1:0]     path_rdata;
    logic [PATH_AW-1:0]      pos_rdata;
    logic                    in_acc;
    logic                    slot_free;
    logic                    on_path_hit;
    logic                    out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_free   = !o_out_valid || i_out_ready;
    assign hold_thr    = hold_data[THREAD_W-1:0];
    assign on_path_hit = r_on_path[hold_thr];
    assign out_load    = slot_free && (r_state == S_EMIT || r_state == S_CLOSE ||
                                       r_state == S_NONE);

    // Table writes; out-of-range values are stored as none / free
    always_comb begin
        tbl_wr          = '0;
        tbl_wr.thread   = i_in_word.thread_index;
        tbl_wr.resource = i_in_word.resource_index;
        tbl_wr.wait_val = i_in_word.wait_resource[3] ? NONE_VAL
                                                     : i_in_word.wait_resource;
        tbl_wr.hold_val = i_in_word.holder_thread[3] ? NONE_VAL
                                                     : i_in_word.holder_thread;
        tbl_wr.wait_we  = in_acc && (i_in_word.op == OP_SET_WAIT);
        tbl_wr.hold_we  = in_acc && (i_in_word.op == OP_SET_HOLDER);
    end

    // Table reads: wait entry of the start or of the newly appended holder
    always_comb begin
        tbl_rd.wait_addr = (r_state == S_START) ? r_start[THREAD_W-1:0] : hold_thr;
        tbl_rd.hold_addr = wait_data[RESOURCE_W-1:0];
    end

    wfgd_tables u_tables (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (tbl_wr),
        .i_rd        (tbl_rd),
        .o_wait_data (wait_data),
        .o_hold_data (hold_data)
    );

    // Path append: start thread, or a holder not yet on the path
    always_comb begin
        path_we    = 1'b0;
        path_waddr = r_len;
        path_wdata = hold_thr;
        if (r_state == S_CHK_START && !wait_data[3]) begin
            path_we    = 1'b1;
            path_waddr = '0;
            path_wdata = r_start[THREAD_W-1:0];
        end else if (r_state == S_HOLD && !hold_data[3] && !on_path_hit) begin
            path_we    = 1'b1;
        end
    end

    // Path store: position -> thread
    wfgd_ram #(.WIDTH(THREAD_W), .DEPTH(PATH_DEPTH)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_waddr),
        .i_wdata (path_wdata),
        .i_raddr (r_ptr),
        .o_rdata (path_rdata)
    );

    // Reverse map: thread -> path position, read on a repeat
    wfgd_ram #(.WIDTH(PATH_AW), .DEPTH(THREAD_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_wdata),
        .i_wdata (path_waddr),
        .i_raddr (hold_thr),
        .o_rdata (pos_rdata)
    );

    // Detection sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_word.op == OP_DETECT) begin
                        r_start <= '0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_start == PATH_AW'(THREAD_COUNT)) begin
                        r_state <= S_NONE;
                    end else begin
                        r_state <= S_CHK_START;
                    end
                end
                S_CHK_START: begin
                    if (wait_data[3]) begin
                        r_start <= r_start + 1'b1;
                        r_state <= S_START;
                    end else begin
                        r_on_path <= THREAD_COUNT'(1) << r_start[THREAD_W-1:0];
                        r_len    <= PATH_AW'(1);
                        r_victim <= r_start[THREAD_W-1:0];
                        r_state  <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (hold_data[3]) begin
                        r_start <= r_start + 1'b1;
                        r_state <= S_START;
                    end else if (on_path_hit) begin
                        r_close <= hold_thr;
                        r_state <= S_POS;
                    end else begin
                        r_on_path[hold_thr] <= 1'b1;
                        r_len    <= r_len + 1'b1;
                        r_victim <= hold_thr;
                        r_state  <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (wait_data[3]) begin
                        r_start <= r_start + 1'b1;
                        r_state <= S_START;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                S_POS: begin
                    r_ptr   <= pos_rdata;
                    r_pos   <= '0;
                    r_clen  <= r_len - pos_rdata + 1'b1;
                    r_state <= S_EMIT_RD;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        o_out_word.found           <= 1'b1;
                        o_out_word.cycle_thread    <= path_rdata;
                        o_out_word.position        <= r_pos;
                        o_out_word.cycle_length    <= r_clen;
                        o_out_word.victim_thread   <= r_victim;
                        o_out_word.last            <= 1'b0;
                        r_pos <= r_pos + 1'b1;
                        r_ptr <= r_ptr + 1'b1;
                        if (r_ptr + 1'b1 == r_len) begin
                            r_state <= S_CLOSE;
                        end else begin
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_CLOSE: begin
                    if (slot_free) begin
                        o_out_word.found           <= 1'b1;
                        o_out_word.cycle_thread    <= r_close;
                        o_out_word.position        <= r_pos;
                        o_out_word.cycle_length    <= r_clen;
                        o_out_word.victim_thread   <= r_victim;
                        o_out_word.last            <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_NONE: begin
                    if (slot_free) begin
                        o_out_word  <= '{found: 1'b0, cycle_thread: '0, position: '0,
                                         cycle_length: '0, victim_thread: '0,
                                         last: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/wfgd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfgd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/wfgd_tables.sv]
// Wait table and holder table: one RAM each, plus per-entry valid bits
// so that unwritten entries read as none / free. Depends on wfgd_pkg, wfgd_ram.
module wfgd_tables (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wfgd_pkg::t_tbl_wr i_wr,
    input  wfgd_pkg::t_tbl_rd i_rd,
    output logic [3:0]       o_wait_data,
    output logic [3:0]       o_hold_data
);
    import wfgd_pkg::*;

    logic [THREAD_COUNT-1:0]   r_wait_vld;
    logic [RESOURCE_COUNT-1:0] r_hold_vld;
    logic                      r_wait_rd_vld;
    logic                      r_hold_rd_vld;
    logic [3:0]                wait_ram_q;
    logic [3:0]                hold_ram_q;

    wfgd_ram #(.WIDTH(4), .DEPTH(THREAD_COUNT)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.wait_we),
        .i_waddr (i_wr.thread),
        .i_wdata (i_wr.wait_val),
        .i_raddr (i_rd.wait_addr),
        .o_rdata (wait_ram_q)
    );

    wfgd_ram #(.WIDTH(4), .DEPTH(RESOURCE_COUNT)) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.hold_we),
        .i_waddr (i_wr.resource),
        .i_wdata (i_wr.hold_val),
        .i_raddr (i_rd.hold_addr),
        .o_rdata (hold_ram_q)
    );

    // Valid bits, sampled alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_vld    <= '0;
            r_hold_vld    <= '0;
            r_wait_rd_vld <= 1'b0;
            r_hold_rd_vld <= 1'b0;
        end else begin
            if (i_wr.wait_we) begin
                r_wait_vld[i_wr.thread] <= 1'b1;
            end
            if (i_wr.hold_we) begin
                r_hold_vld[i_wr.resource] <= 1'b1;
            end
            r_wait_rd_vld <= r_wait_vld[i_rd.wait_addr];
            r_hold_rd_vld <= r_hold_vld[i_rd.hold_addr];
        end
    end

    assign o_wait_data = r_wait_rd_vld ? wait_ram_q : NONE_VAL;
    assign o_hold_data = r_hold_rd_vld ? hold_ram_q : NONE_VAL;

endmodule
